// File: hdl/pzvm_pkg.sv
`timescale 1ns / 1ps

package pzvm_pkg;

    // Fixed-point format of every pan, zoom and window value.
    localparam int FRAC_BITS = 32;
    localparam int EARTH_RADIUS_UNITS = 6378137;

    typedef logic signed [63:0] q_t;

    localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;
    localparam q_t Q_ONE = q_t'(64'd1 << FRAC_BITS);
    localparam q_t Q_TWO = q_t'(64'd2 << FRAC_BITS);
    localparam q_t Q_NEG_TWO = -Q_TWO;

    // Reset values of the window and scale registers, and the zoom that a reset-view action loads.
    localparam longint unsigned NEAR_INT = 64'd100000000;
    localparam q_t NEAR_RST = (NEAR_INT > (64'h7FFF_FFFF_FFFF_FFFF >> FRAC_BITS))
                              ? Q_MAX : q_t'(NEAR_INT << FRAC_BITS);
    localparam q_t FAR_RST = (NEAR_RST == Q_MIN) ? Q_MAX : -NEAR_RST;
    localparam logic [62:0] SCALE_RST =
        63'((64'd11 * (64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam q_t ZOOM_HOME =
        q_t'((64'd1 << FRAC_BITS) / 64'(EARTH_RADIUS_UNITS));

    // Shared unit operations.
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    // Input actions.
    localparam logic [2:0] ACT_PAN     = 3'd0;
    localparam logic [2:0] ACT_ZOOM    = 3'd1;
    localparam logic [2:0] ACT_RESET   = 3'd2;
    localparam logic [2:0] ACT_LOAD    = 3'd3;
    localparam logic [2:0] ACT_REFRESH = 3'd4;

    // Configuration register indexes.
    localparam logic [3:0] CFG_LEFT   = 4'd0;
    localparam logic [3:0] CFG_RIGHT  = 4'd1;
    localparam logic [3:0] CFG_BOTTOM = 4'd2;
    localparam logic [3:0] CFG_TOP    = 4'd3;
    localparam logic [3:0] CFG_NEAR   = 4'd4;
    localparam logic [3:0] CFG_FAR    = 4'd5;
    localparam logic [3:0] CFG_VPW    = 4'd6;
    localparam logic [3:0] CFG_SCALE  = 4'd7;

    typedef struct packed {
        logic start;
        logic op;
        q_t   a;
        q_t   b;
    } alu_req_t;

    typedef struct packed {
        logic done;
        q_t   result;
    } alu_rsp_t;

    function automatic q_t sat_add(input q_t a, input q_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    function automatic q_t sat_sub(input q_t a, input q_t b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    function automatic q_t sat_neg(input q_t a);
        return (a == Q_MIN) ? Q_MAX : -a;
    endfunction

    function automatic logic [63:0] mag(input q_t a);
        return a[63] ? (64'd0 - 64'(a)) : 64'(a);
    endfunction

    // Signed result from a sign and a 128-bit magnitude, saturated.
    function automatic q_t from_mag(input logic neg, input logic [127:0] m);
        if (m[127:63] != '0)
            return neg ? Q_MIN : Q_MAX;
        return neg ? -q_t'(m[63:0]) : q_t'(m[63:0]);
    endfunction

endpackage

// File: hdl/pzvm_alu.sv
`timescale 1ns / 1ps

// Shared multiply and divide unit. A multiply accumulates its partial products
// through one 32x32 multiplier; a divide retires one quotient bit per cycle.
module pzvm_alu
(
    input  logic               clk,
    input  logic               rst_n,
    input  pzvm_pkg::alu_req_t req,
    output pzvm_pkg::alu_rsp_t rsp
);

    localparam int DIV_STEPS = 64 + pzvm_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(3);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    logic             busy_reg;
    logic             fin_reg;
    logic             done_reg;
    logic             op_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [63:0]      x_reg;
    logic [63:0]      y_reg;
    logic [127:0]     acc_reg;
    logic [63:0]      rem_reg;
    pzvm_pkg::q_t     result_reg;

    logic [31:0]  pp_a;
    logic [31:0]  pp_b;
    logic [63:0]  pp;
    logic [127:0] pp_shift;
    logic [64:0]  rem_ext;
    logic [64:0]  rem_diff;
    logic         take_bit;
    logic [127:0] mul_q;

    always_comb
    begin
        pp_a = cnt_reg[1] ? x_reg[63:32] : x_reg[31:0];
        pp_b = cnt_reg[0] ? y_reg[63:32] : y_reg[31:0];
        pp   = 64'(pp_a) * 64'(pp_b);
        case (cnt_reg[1:0])
            2'b00:   pp_shift = 128'(pp);
            2'b11:   pp_shift = 128'(pp) << 64;
            default: pp_shift = 128'(pp) << 32;
        endcase
        rem_ext  = {rem_reg, acc_reg[127]};
        take_bit = rem_ext >= {1'b0, y_reg};
        rem_diff = rem_ext - {1'b0, y_reg};
        mul_q    = acc_reg >> pzvm_pkg::FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            fin_reg    <= 1'b0;
            done_reg   <= 1'b0;
            op_reg     <= pzvm_pkg::OP_MUL;
            neg_reg    <= 1'b0;
            cnt_reg    <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            acc_reg    <= '0;
            rem_reg    <= '0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                op_reg  <= req.op;
                neg_reg <= req.a[63] ^ req.b[63];
                x_reg   <= pzvm_pkg::mag(req.a);
                y_reg   <= pzvm_pkg::mag(req.b);
                acc_reg <= (req.op == pzvm_pkg::OP_DIV)
                           ? {pzvm_pkg::mag(req.a), 64'd0} : 128'd0;
                rem_reg <= '0;
                cnt_reg <= '0;
                fin_reg <= 1'b0;
                if (req.op == pzvm_pkg::OP_DIV && req.b == '0)
                begin
                    // Division by zero resolves at once from the numerator sign.
                    if (req.a == '0)
                        result_reg <= '0;
                    else
                        result_reg <= req.a[63] ? pzvm_pkg::Q_MIN : pzvm_pkg::Q_MAX;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg && fin_reg)
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
                result_reg <= (op_reg == pzvm_pkg::OP_DIV)
                              ? pzvm_pkg::from_mag(neg_reg, acc_reg)
                              : pzvm_pkg::from_mag(neg_reg, mul_q);
            end
            else if (busy_reg)
            begin
                if (op_reg == pzvm_pkg::OP_MUL)
                begin
                    acc_reg <= acc_reg + pp_shift;
                    fin_reg <= (cnt_reg == MUL_LAST);
                end
                else
                begin
                    rem_reg <= take_bit ? rem_diff[63:0] : rem_ext[63:0];
                    acc_reg <= {acc_reg[126:0], take_bit};
                    fin_reg <= (cnt_reg == DIV_LAST);
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign rsp = '{done: done_reg, result: result_reg};

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result reported while the unit is still busy");
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (!busy_reg && !done_reg))
        else $error("operation started while the unit is occupied");
    a_mul_short: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !fin_reg && op_reg == pzvm_pkg::OP_MUL) |-> (cnt_reg <= MUL_LAST))
        else $error("multiply ran past its four partial products");
`endif

endmodule

// File: hdl/pan_zoom_view_matrix_unit.sv
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid / in_ready    action, delta_x, delta_y, zoom_in, new_pan_x,
//                                 new_pan_y, new_zoom
// out      out_valid / out_ready  entry_index, entry_value, last_entry,
//                                 cur_pan_x, cur_pan_y, cur_zoom
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each item runs its program steps on the shared unit, whose divider retires one
// quotient bit per cycle and whose multiplies go through the one 32x32
// multiplier; sixteen output transfers then follow. A divide by zero is resolved
// without running the divider. A new item is taken only once the last entry of
// the item before has been transferred.
// After reset the block is idle and ready; configuration writes are always
// taken. A stalled output holds the block with its entry in the output register.
module pan_zoom_view_matrix_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic signed [63:0] delta_x,
    input  logic signed [63:0] delta_y,
    input  logic        zoom_in,
    input  logic signed [63:0] new_pan_x,
    input  logic signed [63:0] new_pan_y,
    input  logic [62:0] new_zoom,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  entry_index,
    output logic signed [63:0] entry_value,
    output logic        last_entry,
    output logic signed [63:0] cur_pan_x,
    output logic signed [63:0] cur_pan_y,
    output logic [62:0] cur_zoom,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // Program steps. The pan steps come first, then the zoom step, then the
    // matrix steps that every item runs.
    localparam logic [4:0] S_RATIO = 5'd0;
    localparam logic [4:0] S_MULX  = 5'd1;
    localparam logic [4:0] S_DIVX  = 5'd2;
    localparam logic [4:0] S_MULY  = 5'd3;
    localparam logic [4:0] S_DIVY  = 5'd4;
    localparam logic [4:0] S_ZOOM  = 5'd5;
    localparam logic [4:0] S_INVX  = 5'd6;
    localparam logic [4:0] S_M0    = 5'd7;
    localparam logic [4:0] S_M3    = 5'd8;
    localparam logic [4:0] S_INVY  = 5'd9;
    localparam logic [4:0] S_M5    = 5'd10;
    localparam logic [4:0] S_M7    = 5'd11;
    localparam logic [4:0] S_INVZ  = 5'd12;
    localparam logic [4:0] S_M10   = 5'd13;
    localparam logic [4:0] S_M11   = 5'd14;
    localparam logic [4:0] S_M12   = 5'd15;
    localparam logic [4:0] S_M13   = 5'd16;
    localparam logic [4:0] S_PX3   = 5'd17;
    localparam logic [4:0] S_M15   = 5'd18;

    localparam logic [3:0] LAST_IDX = 4'd15;

    // Configuration registers.
    pzvm_pkg::q_t left_reg, right_reg, bottom_reg, top_reg, near_reg, far_reg;
    logic [15:0]  vpw_reg;
    logic [62:0]  scale_reg;

    // View state.
    pzvm_pkg::q_t pan_x_reg, pan_y_reg, zoom_reg;

    // Sequencer.
    logic [1:0] state_reg;
    logic [4:0] pc_reg;
    logic [4:0] pc_next;

    // Latched item fields and working values.
    pzvm_pkg::q_t dx_reg, dy_reg;
    logic         zin_reg;
    pzvm_pkg::q_t ratio_reg, tmp_reg;
    pzvm_pkg::q_t m0_reg, m3_reg, m5_reg, m7_reg, m10_reg, m11_reg;
    pzvm_pkg::q_t m12_reg, m13_reg, m15_reg;

    // Output register.
    logic         out_valid_reg;
    logic [3:0]   idx_reg;
    pzvm_pkg::q_t value_reg;

    pzvm_pkg::alu_req_t alu_req;
    pzvm_pkg::alu_rsp_t alu_rsp;

    pzvm_pkg::q_t wx, wy, wz;
    logic [3:0]   sel_idx;
    pzvm_pkg::q_t sel_value;
    logic         in_fire;
    logic         out_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    assign wx = pzvm_pkg::sat_sub(right_reg, left_reg);
    assign wy = pzvm_pkg::sat_sub(top_reg, bottom_reg);
    assign wz = pzvm_pkg::sat_sub(far_reg, near_reg);

    // Operands for the shared unit, chosen by the current step.
    always_comb
    begin
        alu_req.start = (state_reg == ST_RUN);
        alu_req.op    = pzvm_pkg::OP_DIV;
        alu_req.a     = tmp_reg;
        alu_req.b     = zoom_reg;
        unique case (pc_reg) inside
            S_RATIO:
            begin
                alu_req.a = wx;
                alu_req.b = pzvm_pkg::q_t'(64'(vpw_reg) << pzvm_pkg::FRAC_BITS);
            end
            S_MULX:
            begin
                alu_req.op = pzvm_pkg::OP_MUL;
                alu_req.a  = ratio_reg;
                alu_req.b  = dx_reg;
            end
            S_MULY:
            begin
                alu_req.op = pzvm_pkg::OP_MUL;
                alu_req.a  = ratio_reg;
                alu_req.b  = dy_reg;
            end
            S_DIVX, S_DIVY:
            begin
                alu_req.a = tmp_reg;
                alu_req.b = zoom_reg;
            end
            S_ZOOM:
            begin
                alu_req.op = zin_reg ? pzvm_pkg::OP_MUL : pzvm_pkg::OP_DIV;
                alu_req.a  = zoom_reg;
                alu_req.b  = pzvm_pkg::q_t'({1'b0, scale_reg});
            end
            S_INVX:
            begin
                alu_req.a = pzvm_pkg::Q_TWO;
                alu_req.b = wx;
            end
            S_M3:
            begin
                alu_req.a = pzvm_pkg::sat_neg(pzvm_pkg::sat_add(right_reg, left_reg));
                alu_req.b = wx;
            end
            S_INVY:
            begin
                alu_req.a = pzvm_pkg::Q_TWO;
                alu_req.b = wy;
            end
            S_M7:
            begin
                alu_req.a = pzvm_pkg::sat_neg(pzvm_pkg::sat_add(top_reg, bottom_reg));
                alu_req.b = wy;
            end
            S_INVZ:
            begin
                alu_req.a = pzvm_pkg::Q_NEG_TWO;
                alu_req.b = wz;
            end
            S_M11:
            begin
                alu_req.a = pzvm_pkg::sat_neg(pzvm_pkg::sat_add(far_reg, near_reg));
                alu_req.b = wz;
            end
            S_M0, S_M5, S_M10:
            begin
                alu_req.op = pzvm_pkg::OP_MUL;
                alu_req.a  = tmp_reg;
                alu_req.b  = zoom_reg;
            end
            S_M12:
            begin
                alu_req.op = pzvm_pkg::OP_MUL;
                alu_req.a  = pan_x_reg;
                alu_req.b  = m0_reg;
            end
            S_M13:
            begin
                alu_req.op = pzvm_pkg::OP_MUL;
                alu_req.a  = pan_y_reg;
                alu_req.b  = m5_reg;
            end
            S_PX3:
            begin
                alu_req.op = pzvm_pkg::OP_MUL;
                alu_req.a  = pan_x_reg;
                alu_req.b  = m3_reg;
            end
            S_M15:
            begin
                alu_req.op = pzvm_pkg::OP_MUL;
                alu_req.a  = pan_y_reg;
                alu_req.b  = m7_reg;
            end
            default:
            begin
                alu_req.op = pzvm_pkg::OP_DIV;
            end
        endcase
    end

    // The pan and zoom paths both join the matrix program at its first step.
    assign pc_next = (pc_reg == S_DIVY || pc_reg == S_ZOOM) ? S_INVX : pc_reg + 5'd1;

    // Next entry to place in the output register.
    assign sel_idx = (state_reg == ST_EMIT) ? idx_reg + 4'd1 : 4'd0;

    always_comb
    begin
        case (sel_idx)
            4'd0:    sel_value = m0_reg;
            4'd3:    sel_value = m3_reg;
            4'd5:    sel_value = m5_reg;
            4'd7:    sel_value = m7_reg;
            4'd10:   sel_value = m10_reg;
            4'd11:   sel_value = m11_reg;
            4'd12:   sel_value = m12_reg;
            4'd13:   sel_value = m13_reg;
            4'd15:   sel_value = pzvm_pkg::sat_add(m15_reg, pzvm_pkg::Q_ONE);
            default: sel_value = '0;
        endcase
    end

    pzvm_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= -pzvm_pkg::Q_ONE;
            right_reg  <= pzvm_pkg::Q_ONE;
            bottom_reg <= -pzvm_pkg::Q_ONE;
            top_reg    <= pzvm_pkg::Q_ONE;
            near_reg   <= pzvm_pkg::NEAR_RST;
            far_reg    <= pzvm_pkg::FAR_RST;
            vpw_reg    <= 16'd1024;
            scale_reg  <= pzvm_pkg::SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pzvm_pkg::CFG_LEFT:   left_reg   <= cfg_data;
                pzvm_pkg::CFG_RIGHT:  right_reg  <= cfg_data;
                pzvm_pkg::CFG_BOTTOM: bottom_reg <= cfg_data;
                pzvm_pkg::CFG_TOP:    top_reg    <= cfg_data;
                pzvm_pkg::CFG_NEAR:   near_reg   <= cfg_data;
                pzvm_pkg::CFG_FAR:    far_reg    <= cfg_data;
                pzvm_pkg::CFG_VPW:    vpw_reg    <= cfg_data[15:0];
                pzvm_pkg::CFG_SCALE:  scale_reg  <= cfg_data[62:0];
                default:              ;
            endcase
        end
    end

    // Sequencer, view state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= S_INVX;
            pan_x_reg     <= '0;
            pan_y_reg     <= '0;
            zoom_reg      <= pzvm_pkg::Q_ONE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= ST_RUN;
                        case (action)
                            pzvm_pkg::ACT_PAN:  pc_reg <= S_RATIO;
                            pzvm_pkg::ACT_ZOOM: pc_reg <= S_ZOOM;
                            default:            pc_reg <= S_INVX;
                        endcase
                        if (action == pzvm_pkg::ACT_RESET)
                        begin
                            pan_x_reg <= '0;
                            pan_y_reg <= '0;
                            zoom_reg  <= pzvm_pkg::ZOOM_HOME;
                        end
                        else if (action == pzvm_pkg::ACT_LOAD)
                        begin
                            pan_x_reg <= new_pan_x;
                            pan_y_reg <= new_pan_y;
                            zoom_reg  <= pzvm_pkg::q_t'({1'b0, new_zoom});
                        end
                    end
                end
                ST_RUN:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (alu_rsp.done)
                    begin
                        if (pc_reg == S_DIVX)
                            pan_x_reg <= pzvm_pkg::sat_add(pan_x_reg, alu_rsp.result);
                        if (pc_reg == S_DIVY)
                            pan_y_reg <= pzvm_pkg::sat_sub(pan_y_reg, alu_rsp.result);
                        if (pc_reg == S_ZOOM)
                            zoom_reg <= alu_rsp.result;
                        if (pc_reg == S_M15)
                        begin
                            state_reg     <= ST_EMIT;
                            out_valid_reg <= 1'b1;
                            idx_reg       <= sel_idx;
                        end
                        else
                        begin
                            state_reg <= ST_RUN;
                            pc_reg    <= pc_next;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_fire)
                    begin
                        if (idx_reg == LAST_IDX)
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= sel_idx;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Working values need no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dx_reg  <= delta_x;
            dy_reg  <= delta_y;
            zin_reg <= zoom_in;
        end
        if (state_reg == ST_WAIT && alu_rsp.done)
        begin
            case (pc_reg)
                S_RATIO: ratio_reg <= alu_rsp.result;
                S_M0:    m0_reg    <= alu_rsp.result;
                S_M3:    m3_reg    <= alu_rsp.result;
                S_M5:    m5_reg    <= alu_rsp.result;
                S_M7:    m7_reg    <= alu_rsp.result;
                S_M10:   m10_reg   <= alu_rsp.result;
                S_M11:   m11_reg   <= alu_rsp.result;
                S_M12:   m12_reg   <= alu_rsp.result;
                S_M13:   m13_reg   <= alu_rsp.result;
                S_M15:   m15_reg   <= pzvm_pkg::sat_add(tmp_reg, alu_rsp.result);
                default: tmp_reg   <= alu_rsp.result;
            endcase
        end
        // The value register follows every index load.
        if ((state_reg == ST_WAIT && alu_rsp.done && pc_reg == S_M15) ||
            (state_reg == ST_EMIT && out_fire && idx_reg != LAST_IDX))
        begin
            value_reg <= sel_value;
        end
    end

    assign out_valid   = out_valid_reg;
    assign entry_index = idx_reg;
    assign entry_value = value_reg;
    assign last_entry  = (idx_reg == LAST_IDX);
    assign cur_pan_x   = pan_x_reg;
    assign cur_pan_y   = pan_y_reg;
    assign cur_zoom    = zoom_reg[62:0];

`ifndef NO_ASSERTIONS
    a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_EMIT))
        else $error("output valid outside the emit phase");
    a_alu_waited: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == ST_WAIT))
        else $error("shared unit result arrived with no step waiting");
    a_last_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && idx_reg == LAST_IDX) |=> (!out_valid_reg && in_ready))
        else $error("block did not return to idle after the last entry");
`endif

endmodule
